// ----- design/mid_pkg.sv -----
package mid_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_OPCODE = 2'd1;
    localparam logic [1:0] ST_BAD_REG    = 2'd2;

    localparam logic [1:0] FORM_REG_RM  = 2'd0;
    localparam logic [1:0] FORM_IMM_REG = 2'd1;
    localparam logic [1:0] FORM_IMM_RM  = 2'd2;
    localparam logic [1:0] FORM_ACC     = 2'd3;

    localparam logic [1:0] MOD_MEM    = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP16 = 2'b10;
    localparam logic [2:0] RM_DIRECT  = 3'b110;
    localparam logic [2:0] REG_ZERO   = 3'b000;

    localparam logic [5:0] OP_RM_REG  = 6'b100010;
    localparam logic [3:0] OP_IMM_REG = 4'b1011;
    localparam logic [6:0] OP_IMM_RM  = 7'b1100011;
    localparam logic [5:0] OP_ACC     = 6'b101000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MODRM,
        PH_DISP,
        PH_IMM,
        PH_ADDR
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_OPCODE,
        ROLE_MODRM,
        ROLE_DISP8,
        ROLE_DISP_LO,
        ROLE_DISP_HI,
        ROLE_DATA8,
        ROLE_DATA_LO,
        ROLE_DATA_HI
    } t_role;

    typedef struct packed {
        logic [7:0] code;
        t_role      role;
        logic       last;
        logic [1:0] status;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token token;
    } t_qslot;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  form;
        logic        word_size;
        logic        direction;
        logic [2:0]  reg_field;
        logic [1:0]  mode_field;
        logic [2:0]  rm_field;
        logic        direct_ea;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [15:0] memory_offset;
    } t_result;

    function automatic logic is_rm_reg(input logic [7:0] op);
        return op[7:2] == OP_RM_REG;
    endfunction

    function automatic logic is_imm_reg(input logic [7:0] op);
        return op[7:4] == OP_IMM_REG;
    endfunction

    function automatic logic is_imm_rm(input logic [7:0] op);
        return op[7:1] == OP_IMM_RM;
    endfunction

    function automatic logic is_acc(input logic [7:0] op);
        return op[7:2] == OP_ACC;
    endfunction

    function automatic logic is_direct(input logic [7:0] modrm);
        return (modrm[7:6] == MOD_MEM) && (modrm[2:0] == RM_DIRECT);
    endfunction

    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] len;
        len = 2'd0;
        if (modrm[7:6] == MOD_DISP8) begin
            len = 2'd1;
        end else if (modrm[7:6] == MOD_DISP16 || is_direct(modrm)) begin
            len = 2'd2;
        end
        return len;
    endfunction

    function automatic logic [1:0] form_of(input logic [7:0] op);
        logic [1:0] f;
        if (is_rm_reg(op)) begin
            f = FORM_REG_RM;
        end else if (is_imm_reg(op)) begin
            f = FORM_IMM_REG;
        end else if (is_imm_rm(op)) begin
            f = FORM_IMM_RM;
        end else begin
            f = FORM_ACC;
        end
        return f;
    endfunction

endpackage

// ----- design/mid_byte_if.sv -----
interface mid_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source(output valid, output code_byte, input ready);
    modport sink(input valid, input code_byte, output ready);
endinterface

// ----- design/mid_result_if.sv -----
interface mid_result_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic        [1:0]  form;
    logic               word_size;
    logic               direction;
    logic        [2:0]  reg_field;
    logic        [1:0]  mode_field;
    logic        [2:0]  rm_field;
    logic               direct_ea;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic        [15:0] memory_offset;

    modport source(
        output valid, output status, output form, output word_size, output direction,
        output reg_field, output mode_field, output rm_field, output direct_ea,
        output displacement, output immediate, output memory_offset,
        input ready
    );
    modport sink(
        input valid, input status, input form, input word_size, input direction,
        input reg_field, input mode_field, input rm_field, input direct_ea,
        input displacement, input immediate, input memory_offset,
        output ready
    );
endinterface

// ----- design/mov_instruction_decoder_unit.sv -----
// Byte-serial decoder for the 16-bit x86 MOV forms (88-8B, A0-A3, B0-BF, C6-C7). One code
// byte is taken per cycle, without gaps, as long as the result side keeps up. A classifier
// tags each byte with its role in the instruction and pushes it into a four-entry token
// queue; an assembler behind the queue gathers ModRM, displacement and immediate or offset
// bytes and loads one registered result on the last byte of each instruction. With the queue
// empty and the result register free, the last byte passes through a queue slot and then the
// result register before that result is valid. Unsupported opcodes and C6/C7 with a nonzero
// reg field give an error result on the byte that reveals them; decoding restarts at the next
// byte. The classifier sets the rate: it resolves one byte per cycle while the queue has room.
module mov_instruction_decoder_unit
    import mid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mid_byte_if.sink          i_code,
    mid_result_if.source      o_result
);

    t_qslot  push;
    t_qslot  head;
    logic    q_full;
    logic    pop;
    logic    res_valid;
    t_result res;

    mid_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_code.valid),
        .i_code_byte (i_code.code_byte),
        .o_ready     (i_code.ready),
        .i_full      (q_full),
        .o_push      (push)
    );

    mid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    mid_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (res_valid),
        .i_ready  (o_result.ready),
        .o_result (res)
    );

    assign o_result.valid         = res_valid;
    assign o_result.status        = res.status;
    assign o_result.form          = res.form;
    assign o_result.word_size     = res.word_size;
    assign o_result.direction     = res.direction;
    assign o_result.reg_field     = res.reg_field;
    assign o_result.mode_field    = res.mode_field;
    assign o_result.rm_field      = res.rm_field;
    assign o_result.direct_ea     = res.direct_ea;
    assign o_result.displacement  = $signed(res.displacement);
    assign o_result.immediate     = $signed(res.immediate);
    assign o_result.memory_offset = res.memory_offset;

`ifndef NO_ASSERTIONS
    a_accept_enters_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_code.valid && i_code.ready) |-> push.valid && !q_full)
        else $error("accepted byte did not enter the token queue");

    a_last_token_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && head.valid && head.token.last) |=> o_result.valid)
        else $error("final token of an instruction gave no result");

    a_error_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_OK) |->
        (o_result.immediate == 16'sd0 && o_result.displacement == 16'sd0 &&
         o_result.memory_offset == 16'd0))
        else $error("error result carries operand data");

    a_offset_only_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.form != FORM_ACC) |-> o_result.memory_offset == 16'd0)
        else $error("memory offset set outside the accumulator form");
`endif

endmodule

// ----- design/mid_front.sv -----
module mid_front
    import mid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_code_byte,
    output logic       o_ready,
    input  logic       i_full,
    output t_qslot     o_push
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_opcode, n_opcode;
    logic [1:0] r_left, n_left;
    logic       r_wide, n_wide;
    logic       fire;
    logic       w_imm;
    t_token     tok;

    assign o_ready      = !i_full;
    assign fire         = i_valid && !i_full;
    assign o_push.valid = fire;
    assign o_push.token = tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_opcode <= '0;
            r_left   <= '0;
            r_wide   <= 1'b0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_left   <= n_left;
            r_wide   <= n_wide;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_left     = r_left;
        n_wide     = r_wide;
        tok.code   = i_code_byte;
        tok.role   = ROLE_OPCODE;
        tok.last   = 1'b0;
        tok.status = ST_OK;
        w_imm      = is_imm_rm(r_opcode) ? r_opcode[0] : r_opcode[3];
        case (r_phase)
            PH_MODRM: begin
                tok.role = ROLE_MODRM;
                if (is_imm_rm(r_opcode) && i_code_byte[5:3] != REG_ZERO) begin
                    tok.last   = 1'b1;
                    tok.status = ST_BAD_REG;
                    n_phase    = PH_IDLE;
                end else if (disp_len(i_code_byte) != 2'd0) begin
                    n_phase = PH_DISP;
                    n_left  = disp_len(i_code_byte);
                    n_wide  = (disp_len(i_code_byte) == 2'd2);
                end else if (is_imm_rm(r_opcode)) begin
                    n_phase = PH_IMM;
                    n_left  = r_opcode[0] ? 2'd2 : 2'd1;
                    n_wide  = r_opcode[0];
                end else begin
                    tok.last = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
            PH_DISP: begin
                tok.role = r_wide ? ((r_left == 2'd2) ? ROLE_DISP_LO : ROLE_DISP_HI)
                                  : ROLE_DISP8;
                n_left   = r_left - 2'd1;
                if (r_left == 2'd1) begin
                    if (is_imm_rm(r_opcode)) begin
                        n_phase = PH_IMM;
                        n_left  = r_opcode[0] ? 2'd2 : 2'd1;
                        n_wide  = r_opcode[0];
                    end else begin
                        tok.last = 1'b1;
                        n_phase  = PH_IDLE;
                    end
                end
            end
            PH_IMM: begin
                tok.role = w_imm ? ((r_left == 2'd2) ? ROLE_DATA_LO : ROLE_DATA_HI)
                                 : ROLE_DATA8;
                n_left   = r_left - 2'd1;
                if (r_left == 2'd1) begin
                    tok.last = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
            PH_ADDR: begin
                tok.role = (r_left == 2'd2) ? ROLE_DATA_LO : ROLE_DATA_HI;
                n_left   = r_left - 2'd1;
                if (r_left == 2'd1) begin
                    tok.last = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
            default: begin
                n_opcode = i_code_byte;
                if (is_rm_reg(i_code_byte) || is_imm_rm(i_code_byte)) begin
                    n_phase = PH_MODRM;
                end else if (is_imm_reg(i_code_byte)) begin
                    n_phase = PH_IMM;
                    n_left  = i_code_byte[3] ? 2'd2 : 2'd1;
                    n_wide  = i_code_byte[3];
                end else if (is_acc(i_code_byte)) begin
                    n_phase = PH_ADDR;
                    n_left  = 2'd2;
                    n_wide  = 1'b1;
                end else begin
                    tok.last   = 1'b1;
                    tok.status = ST_BAD_OPCODE;
                    n_phase    = PH_IDLE;
                end
            end
        endcase
    end

endmodule

// ----- design/mid_queue.sv -----
module mid_queue
    import mid_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qslot i_push,
    output logic   o_full,
    output t_qslot o_head,
    input  logic   i_pop
);

    t_token              r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full       = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.token = r_slot[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/mid_back.sv -----
module mid_back
    import mid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qslot  i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [7:0]  r_opcode, n_opcode;
    logic [7:0]  r_modrm, n_modrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_data, n_data;
    logic        r_out_valid;
    t_result     r_out;
    t_result     res;
    t_token      tok;

    assign tok      = i_head.token;
    assign o_pop    = i_head.valid && (!tok.last || !r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode    <= '0;
            r_modrm     <= '0;
            r_disp      <= '0;
            r_data      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_opcode <= n_opcode;
                r_modrm  <= n_modrm;
                r_disp   <= n_disp;
                r_data   <= n_data;
            end
            if (o_pop && tok.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && tok.last) begin
            r_out <= res;
        end
    end

    always_comb begin
        n_opcode = r_opcode;
        n_modrm  = r_modrm;
        n_disp   = r_disp;
        n_data   = r_data;
        case (tok.role)
            ROLE_OPCODE: begin
                n_opcode = tok.code;
                n_data   = '0;
            end
            ROLE_MODRM: begin
                n_modrm = tok.code;
                n_disp  = '0;
            end
            ROLE_DISP8:   n_disp = {{8{tok.code[7]}}, tok.code};
            ROLE_DISP_LO: n_disp = {8'h00, tok.code};
            ROLE_DISP_HI: n_disp = {tok.code, r_disp[7:0]};
            ROLE_DATA8:   n_data = {{8{tok.code[7]}}, tok.code};
            ROLE_DATA_LO: n_data = {8'h00, tok.code};
            ROLE_DATA_HI: n_data = {tok.code, r_data[7:0]};
            default: begin
                n_opcode = r_opcode;
            end
        endcase
    end

    always_comb begin
        res        = '0;
        res.status = tok.status;
        case (tok.status)
            ST_BAD_REG: begin
                res.form       = FORM_IMM_RM;
                res.word_size  = n_opcode[0];
                res.reg_field  = n_modrm[5:3];
                res.mode_field = n_modrm[7:6];
                res.rm_field   = n_modrm[2:0];
            end
            ST_OK: begin
                res.form = form_of(n_opcode);
                case (form_of(n_opcode))
                    FORM_REG_RM: begin
                        res.word_size    = n_opcode[0];
                        res.direction    = n_opcode[1];
                        res.reg_field    = n_modrm[5:3];
                        res.mode_field   = n_modrm[7:6];
                        res.rm_field     = n_modrm[2:0];
                        res.direct_ea    = is_direct(n_modrm);
                        res.displacement = n_disp;
                    end
                    FORM_IMM_REG: begin
                        res.word_size = n_opcode[3];
                        res.direction = 1'b1;
                        res.reg_field = n_opcode[2:0];
                        res.immediate = n_data;
                    end
                    FORM_IMM_RM: begin
                        res.word_size    = n_opcode[0];
                        res.mode_field   = n_modrm[7:6];
                        res.rm_field     = n_modrm[2:0];
                        res.direct_ea    = is_direct(n_modrm);
                        res.displacement = n_disp;
                        res.immediate    = n_data;
                    end
                    default: begin
                        res.word_size     = n_opcode[0];
                        res.direction     = n_opcode[1];
                        res.memory_offset = n_data;
                    end
                endcase
            end
            default: begin
                res.status = tok.status;
            end
        endcase
    end

endmodule

// ----- tb/tb_mov_instruction_decoder_unit.sv -----
module tb_mov_instruction_decoder_unit
    import mid_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_N      = 26;
    localparam int RAND_ITEMS = 1200;
    localparam int LONG_HOLD  = 400;

    localparam t_result NO_RES = '0;

    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        t_result    res;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mid_byte_if   code_if ();
    mid_result_if res_if ();

    mov_instruction_decoder_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_code   (code_if),
        .o_result (res_if)
    );

    t_dir_row   dir_rows [DIR_N];
    t_result    mov_results_q [$];
    logic [7:0] code_q [$];
    int         err_count      = 0;
    int         accepted_bytes = 0;
    bit         quiet_phase    = 1'b0;
    bit         long_hold_done = 1'b0;

    t_phase      dec_phase  = PH_IDLE;
    logic [7:0]  dec_opcode = '0;
    logic [7:0]  dec_modrm  = '0;
    logic [15:0] dec_disp   = '0;
    logic [15:0] dec_data   = '0;
    logic [1:0]  dec_left   = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result mk_res(input logic [1:0] st, input logic [1:0] fm,
                                       input logic w, input logic d, input logic [2:0] rg,
                                       input logic [1:0] md, input logic [2:0] rm_v,
                                       input logic dir, input logic [15:0] disp,
                                       input logic [15:0] imm, input logic [15:0] moff);
        t_result r;
        r.status        = st;
        r.form          = fm;
        r.word_size     = w;
        r.direction     = d;
        r.reg_field     = rg;
        r.mode_field    = md;
        r.rm_field      = rm_v;
        r.direct_ea     = dir;
        r.displacement  = disp;
        r.immediate     = imm;
        r.memory_offset = moff;
        return r;
    endfunction

    function automatic logic [1:0] disp_bytes(input logic [7:0] m);
        if (m[7:6] == MOD_DISP8) begin
            return 2'd1;
        end
        if (m[7:6] == MOD_DISP16 || (m[7:6] == MOD_MEM && m[2:0] == RM_DIRECT)) begin
            return 2'd2;
        end
        return 2'd0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic take_byte(inout logic [15:0] acc, input logic [1:0] total,
                             input logic [7:0] b);
        if (total == 2'd2 && dec_left == 2'd2) begin
            acc = {8'h00, b};
        end else if (total == 2'd2) begin
            acc = acc | {b, 8'h00};
        end else begin
            acc = {{8{b[7]}}, b};
        end
        if (dec_left != 2'd0) begin
            dec_left = dec_left - 2'd1;
        end
    endtask

    task automatic finish_operand(output bit produced, output t_result r);
        logic       w;
        logic [1:0] md;
        logic [2:0] rm_v;
        w        = dec_opcode[0];
        md       = dec_modrm[7:6];
        rm_v     = dec_modrm[2:0];
        produced = 1'b0;
        r        = NO_RES;
        if (dec_opcode[7:1] == OP_IMM_RM) begin
            dec_phase = PH_IMM;
            dec_left  = w ? 2'd2 : 2'd1;
            dec_data  = '0;
        end else begin
            dec_phase = PH_IDLE;
            produced  = 1'b1;
            r = mk_res(ST_OK, FORM_REG_RM, w, dec_opcode[1], dec_modrm[5:3], md, rm_v,
                       md == MOD_MEM && rm_v == RM_DIRECT, dec_disp, 16'h0000, 16'h0000);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, output bit produced, output t_result r);
        logic       w;
        logic       imm_rm;
        logic [1:0] md;
        logic [2:0] rm_v;
        produced = 1'b0;
        r        = NO_RES;
        imm_rm   = dec_opcode[7:1] == OP_IMM_RM;
        case (dec_phase)
            PH_MODRM: begin
                dec_modrm = b;
                dec_disp  = '0;
                md        = b[7:6];
                rm_v      = b[2:0];
                if (imm_rm && b[5:3] != REG_ZERO) begin
                    dec_phase = PH_IDLE;
                    produced  = 1'b1;
                    r = mk_res(ST_BAD_REG, FORM_IMM_RM, dec_opcode[0], 1'b0, b[5:3], md, rm_v,
                               1'b0, 16'h0000, 16'h0000, 16'h0000);
                end else begin
                    dec_left = disp_bytes(b);
                    if (dec_left != 2'd0) begin
                        dec_phase = PH_DISP;
                    end else begin
                        finish_operand(produced, r);
                    end
                end
            end
            PH_DISP: begin
                take_byte(dec_disp, disp_bytes(dec_modrm), b);
                if (dec_left == 2'd0) begin
                    finish_operand(produced, r);
                end
            end
            PH_IMM: begin
                w = imm_rm ? dec_opcode[0] : dec_opcode[3];
                take_byte(dec_data, w ? 2'd2 : 2'd1, b);
                if (dec_left == 2'd0) begin
                    dec_phase = PH_IDLE;
                    produced  = 1'b1;
                    md        = dec_modrm[7:6];
                    rm_v      = dec_modrm[2:0];
                    if (imm_rm) begin
                        r = mk_res(ST_OK, FORM_IMM_RM, w, 1'b0, REG_ZERO, md, rm_v,
                                   md == MOD_MEM && rm_v == RM_DIRECT, dec_disp, dec_data,
                                   16'h0000);
                    end else begin
                        r = mk_res(ST_OK, FORM_IMM_REG, w, 1'b1, dec_opcode[2:0], 2'b00, 3'b000,
                                   1'b0, 16'h0000, dec_data, 16'h0000);
                    end
                end
            end
            PH_ADDR: begin
                take_byte(dec_data, 2'd2, b);
                if (dec_left == 2'd0) begin
                    dec_phase = PH_IDLE;
                    produced  = 1'b1;
                    r = mk_res(ST_OK, FORM_ACC, dec_opcode[0], dec_opcode[1], 3'b000, 2'b00,
                               3'b000, 1'b0, 16'h0000, 16'h0000, dec_data);
                end
            end
            default: begin
                dec_opcode = b;
                if (b[7:2] == OP_RM_REG || b[7:1] == OP_IMM_RM) begin
                    dec_phase = PH_MODRM;
                end else if (b[7:4] == OP_IMM_REG) begin
                    dec_phase = PH_IMM;
                    dec_left  = b[3] ? 2'd2 : 2'd1;
                    dec_data  = '0;
                end else if (b[7:2] == OP_ACC) begin
                    dec_phase = PH_ADDR;
                    dec_left  = 2'd2;
                    dec_data  = '0;
                end else begin
                    dec_phase = PH_IDLE;
                    produced  = 1'b1;
                    r = mk_res(ST_BAD_OPCODE, FORM_REG_RM, 1'b0, 1'b0, 3'b000, 2'b00, 3'b000,
                               1'b0, 16'h0000, 16'h0000, 16'h0000);
                end
            end
        endcase
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            code_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        code_if.valid     <= 1'b1;
        code_if.code_byte <= b;
        do @(posedge i_clk); while (!code_if.ready);
    endtask

    task automatic build_instr();
        int         kind;
        logic [7:0] op;
        logic [7:0] modrm;
        int         n_disp;
        int         n_imm;
        kind   = $urandom_range(0, 99);
        n_disp = 0;
        n_imm  = 0;
        modrm  = {2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7))};
        if ($urandom_range(0, 4) == 0) begin
            modrm[7:6] = MOD_MEM;
            modrm[2:0] = RM_DIRECT;
        end
        if (kind >= 90) begin
            code_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind >= 80) begin
            modrm[5:3] = 3'($urandom_range(1, 7));
            code_q.push_back({OP_IMM_RM, 1'($urandom_range(0, 1))});
            code_q.push_back(modrm);
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    op     = {OP_RM_REG, 2'($urandom_range(0, 3))};
                    n_disp = int'(disp_bytes(modrm));
                    code_q.push_back(op);
                    code_q.push_back(modrm);
                end
                1: begin
                    op    = {OP_IMM_REG, 4'($urandom_range(0, 15))};
                    n_imm = op[3] ? 2 : 1;
                    code_q.push_back(op);
                end
                2: begin
                    op         = {OP_IMM_RM, 1'($urandom_range(0, 1))};
                    modrm[5:3] = REG_ZERO;
                    n_disp     = int'(disp_bytes(modrm));
                    n_imm      = op[0] ? 2 : 1;
                    code_q.push_back(op);
                    code_q.push_back(modrm);
                end
                default: begin
                    code_q.push_back({OP_ACC, 2'($urandom_range(0, 3))});
                    n_imm = 2;
                end
            endcase
            repeat (n_disp + n_imm) code_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge i_clk) begin
        bit      produced;
        t_result predicted;
        t_result want;
        if (i_rst_n) begin
            if (code_if.valid && code_if.ready) begin
                decode_byte(code_if.code_byte, produced, predicted);
                if (accepted_bytes < DIR_N && dir_rows[accepted_bytes].typed) begin
                    mov_results_q.push_back(dir_rows[accepted_bytes].res);
                end else if (produced) begin
                    mov_results_q.push_back(predicted);
                end
                accepted_bytes++;
            end
            if (res_if.valid && res_if.ready) begin
                if (mov_results_q.size() == 0) begin
                    $error("result transfer with no decode pending");
                    err_count++;
                end else begin
                    want = mov_results_q.pop_front();
                    cmp_field("status", 16'(want.status), 16'(res_if.status));
                    cmp_field("form", 16'(want.form), 16'(res_if.form));
                    cmp_field("word_size", 16'(want.word_size), 16'(res_if.word_size));
                    cmp_field("direction", 16'(want.direction), 16'(res_if.direction));
                    cmp_field("reg_field", 16'(want.reg_field), 16'(res_if.reg_field));
                    cmp_field("mode_field", 16'(want.mode_field), 16'(res_if.mode_field));
                    cmp_field("rm_field", 16'(want.rm_field), 16'(res_if.rm_field));
                    cmp_field("direct_ea", 16'(want.direct_ea), 16'(res_if.direct_ea));
                    cmp_field("displacement", want.displacement, res_if.displacement);
                    cmp_field("immediate", want.immediate, res_if.immediate);
                    cmp_field("memory_offset", want.memory_offset, res_if.memory_offset);
                end
            end
        end
    end

    initial begin
        int gap;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!long_hold_done && accepted_bytes >= 200) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            gap = pick_gap();
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        int random_sent;
        random_sent = 0;
        i_rst_n           <= 1'b0;
        code_if.valid     <= 1'b0;
        code_if.code_byte <= 8'h00;

        dir_rows[0]  = {8'h00, 1'b1, mk_res(ST_BAD_OPCODE, FORM_REG_RM, 1'b0, 1'b0, 3'd0, 2'd0,
                                            3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000)};
        dir_rows[1]  = {8'h8B, 1'b0, NO_RES};
        dir_rows[2]  = {8'h06, 1'b0, NO_RES};
        dir_rows[3]  = {8'h34, 1'b0, NO_RES};
        dir_rows[4]  = {8'h12, 1'b0, NO_RES};
        dir_rows[5]  = {8'h88, 1'b0, NO_RES};
        dir_rows[6]  = {8'h47, 1'b0, NO_RES};
        dir_rows[7]  = {8'h80, 1'b0, NO_RES};
        dir_rows[8]  = {8'hC6, 1'b0, NO_RES};
        dir_rows[9]  = {8'h80, 1'b0, NO_RES};
        dir_rows[10] = {8'h00, 1'b0, NO_RES};
        dir_rows[11] = {8'h80, 1'b0, NO_RES};
        dir_rows[12] = {8'h7F, 1'b0, NO_RES};
        dir_rows[13] = {8'hB0, 1'b0, NO_RES};
        dir_rows[14] = {8'hFF, 1'b1, mk_res(ST_OK, FORM_IMM_REG, 1'b0, 1'b1, 3'd0, 2'd0, 3'd0,
                                            1'b0, 16'h0000, 16'hFFFF, 16'h0000)};
        dir_rows[15] = {8'hBF, 1'b0, NO_RES};
        dir_rows[16] = {8'h00, 1'b0, NO_RES};
        dir_rows[17] = {8'h80, 1'b0, NO_RES};
        dir_rows[18] = {8'hC6, 1'b0, NO_RES};
        dir_rows[19] = {8'hF8, 1'b1, mk_res(ST_BAD_REG, FORM_IMM_RM, 1'b0, 1'b0, 3'd7, 2'd3,
                                            3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000)};
        dir_rows[20] = {8'hA1, 1'b0, NO_RES};
        dir_rows[21] = {8'hFF, 1'b0, NO_RES};
        dir_rows[22] = {8'hFF, 1'b1, mk_res(ST_OK, FORM_ACC, 1'b1, 1'b0, 3'd0, 2'd0, 3'd0,
                                            1'b0, 16'h0000, 16'h0000, 16'hFFFF)};
        dir_rows[23] = {8'hA2, 1'b0, NO_RES};
        dir_rows[24] = {8'h00, 1'b0, NO_RES};
        dir_rows[25] = {8'h00, 1'b1, mk_res(ST_OK, FORM_ACC, 1'b0, 1'b1, 3'd0, 2'd0, 3'd0,
                                            1'b0, 16'h0000, 16'h0000, 16'h0000)};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            send_byte(dir_rows[i].code);
        end

        while (random_sent < RAND_ITEMS) begin
            if ($urandom_range(0, 29) == 0) begin
                quiet_phase = !quiet_phase;
            end
            build_instr();
            while (code_q.size() != 0) begin
                send_byte(code_q.pop_front());
                random_sent++;
            end
        end
        code_if.valid <= 1'b0;
        @(posedge i_clk);

        while (mov_results_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && mov_results_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
